// File: hdl/pol_pkg.sv
// Shared types and codes for the positional ordered list.
`timescale 1ns / 1ps

package pol_pkg;

    localparam int VALUE_W  = 32;
    localparam int POS_W    = 6;
    localparam int ACTION_W = 2;
    localparam int STATUS_W = 2;
    localparam int FOUND_W  = 5;
    localparam int COUNT_W  = 6;

    localparam logic [ACTION_W-1:0] ACT_INSERT    = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_REMOVE_AT = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_REMOVE_EQ = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_SEARCH    = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_POS   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

    // Compare request broadcast to every cell when a transaction is taken.
    typedef struct packed {
        logic                      en;
        logic signed [VALUE_W-1:0] key;
    } probe_t;

    // Update broadcast to every cell on commit.
    typedef struct packed {
        logic                      ins;
        logic                      rm_pos;
        logic                      rm_match;
        logic [POS_W-1:0]          pos;
        logic signed [VALUE_W-1:0] value;
    } cmd_t;

endpackage

// File: hdl/pol_cell.sv
// One storage cell of the list row: holds an entry, compares, shifts.
`timescale 1ns / 1ps

module pol_cell #(
    parameter int IDX = 0,
    parameter int PW  = 6
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  pol_pkg::probe_t                     probe,
    input  pol_pkg::cmd_t                       cmd,
    input  logic                                live,
    input  logic                                tail,
    input  logic signed [pol_pkg::VALUE_W-1:0]  left_data,
    input  logic signed [pol_pkg::VALUE_W-1:0]  right_data,
    output logic signed [pol_pkg::VALUE_W-1:0]  data,
    output logic                                hit
);

    localparam logic [PW-1:0] MY_IDX = PW'(IDX);

    logic signed [pol_pkg::VALUE_W-1:0] data_reg;
    logic signed [pol_pkg::VALUE_W-1:0] data_next;
    logic                               hit_reg;
    logic                               hit_next;
    logic [PW-1:0]                      pos_ext;

    assign pos_ext = PW'(cmd.pos);

    always_comb
    begin
        hit_next = hit_reg;
        if (probe.en)
        begin
            hit_next = live && (data_reg == probe.key);
        end
    end

    // Insert opens a gap at pos; removes close the gap from the right.
    always_comb
    begin
        data_next = data_reg;
        if (cmd.ins && (MY_IDX > pos_ext))
        begin
            data_next = left_data;
        end
        else if (cmd.ins && (MY_IDX == pos_ext))
        begin
            data_next = cmd.value;
        end
        else if ((cmd.rm_pos && (MY_IDX >= pos_ext)) || (cmd.rm_match && tail))
        begin
            data_next = right_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else
        begin
            hit_reg <= hit_next;
        end
    end

    assign data = data_reg;
    assign hit  = hit_reg;

endmodule

// File: hdl/pol_first.sv
// First-match finder over the row of hit flags.
`timescale 1ns / 1ps

module pol_first #(
    parameter int N  = 32,
    parameter int IW = 5
) (
    input  logic [N-1:0]  hit,
    output logic          any,
    output logic [N-1:0]  tail,
    output logic [IW-1:0] index
);

    logic [N-1:0] neg;
    logic [N-1:0] low;

    // x | -x marks the lowest set bit and everything above it.
    assign neg  = ~hit + N'(1);
    assign tail = hit | neg;
    assign low  = hit & neg;
    assign any  = |hit;

    for (genvar b = 0; b < IW; b++)
    begin : g_bit
        logic [N-1:0] sel;
        for (genvar i = 0; i < N; i++)
        begin : g_term
            if (((i >> b) % 2) == 1)
            begin : g_one
                assign sel[i] = low[i];
            end
            else
            begin : g_zero
                assign sel[i] = 1'b0;
            end
        end
        assign index[b] = |sel;
    end

endmodule

// File: hdl/positional_ordered_list_core.sv
// Top level of the positional ordered list: cell row, sequencer, result register.
// result_valid rises once the held transaction commits into the result register.
// A new transaction waits until the held one commits: the cell row compares on
//   acceptance, shifts on commit; a full, stalled result register holds the shift.
// Reset (rst_n, async, active low) clears the count, sequencer and result valid.
// Entry contents are undefined after reset; no clearing pass is run.
`timescale 1ns / 1ps

module positional_ordered_list_core #(
    parameter int CAPACITY = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 item_valid,
    output logic                                 item_stall,
    input  logic [pol_pkg::ACTION_W-1:0]         action,
    input  logic signed [pol_pkg::VALUE_W-1:0]   value,
    input  logic [pol_pkg::POS_W-1:0]            position,
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output logic [pol_pkg::STATUS_W-1:0]         status,
    output logic [pol_pkg::FOUND_W-1:0]          found_position,
    output logic [pol_pkg::COUNT_W-1:0]          item_count,
    output logic                                 is_empty
);

    // Count width holds CAPACITY itself; index width addresses one cell.
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);
    // Compare widths: cell index vs. position, and count vs. position.
    localparam int PW = (IW > pol_pkg::POS_W) ? IW : pol_pkg::POS_W;
    localparam int XW = (CW > pol_pkg::POS_W) ? CW : pol_pkg::POS_W;

    // Sequencer: IDLE takes a transaction (cells latch compare flags),
    // EXEC decides and commits the shift once the result slot is free.
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic                                 state_reg;
    logic                                 state_next;
    logic [CW-1:0]                        count_reg;
    logic [CW-1:0]                        count_next;
    logic [pol_pkg::ACTION_W-1:0]         act_reg;
    logic signed [pol_pkg::VALUE_W-1:0]   val_reg;
    logic [pol_pkg::POS_W-1:0]            pos_reg;

    logic                                 res_valid_reg;
    logic                                 res_valid_next;
    logic [pol_pkg::STATUS_W-1:0]         res_status_reg;
    logic [pol_pkg::FOUND_W-1:0]          res_found_reg;
    logic [pol_pkg::COUNT_W-1:0]          res_count_reg;
    logic                                 res_empty_reg;

    logic                                 accept;
    logic                                 commit;
    logic [pol_pkg::STATUS_W-1:0]         status_calc;
    logic [pol_pkg::FOUND_W-1:0]          found_calc;
    logic                                 do_ins;
    logic                                 do_rm_pos;
    logic                                 do_rm_match;
    logic [XW-1:0]                        pos_x;
    logic [XW-1:0]                        cnt_x;

    pol_pkg::probe_t                      probe;
    pol_pkg::cmd_t                        cmd;

    logic signed [pol_pkg::VALUE_W-1:0]   cell_data [CAPACITY];
    logic [CAPACITY-1:0]                  live;
    logic [CAPACITY-1:0]                  hit;
    logic [CAPACITY-1:0]                  tail;
    logic                                 any_hit;
    logic [IW-1:0]                        hit_index;

    assign item_stall = (state_reg != ST_IDLE);
    assign accept     = item_valid && !item_stall;
    assign commit     = (state_reg == ST_EXEC) && (!res_valid_reg || !result_stall);

    // Compare flags are sampled against the incoming value on acceptance.
    assign probe.en  = accept;
    assign probe.key = value;

    // ---------------------------------------------------------------
    // Cell row: each cell sees its neighbors; the ends tie to themselves.
    // ---------------------------------------------------------------
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [pol_pkg::VALUE_W-1:0] left_d;
        logic signed [pol_pkg::VALUE_W-1:0] right_d;

        if (i == 0)
        begin : g_first
            assign left_d = cell_data[i];
        end
        else
        begin : g_mid_l
            assign left_d = cell_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_d = cell_data[i];
        end
        else
        begin : g_mid_r
            assign right_d = cell_data[i+1];
        end

        assign live[i] = (CW'(i) < count_reg);

        pol_cell #(
            .IDX (i),
            .PW  (PW)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .probe      (probe),
            .cmd        (cmd),
            .live       (live[i]),
            .tail       (tail[i]),
            .left_data  (left_d),
            .right_data (right_d),
            .data       (cell_data[i]),
            .hit        (hit[i])
        );
    end

    pol_first #(
        .N  (CAPACITY),
        .IW (IW)
    ) u_first (
        .hit   (hit),
        .any   (any_hit),
        .tail  (tail),
        .index (hit_index)
    );

    // ---------------------------------------------------------------
    // Decision for the held transaction.
    // Insert checks position before capacity.
    // ---------------------------------------------------------------
    assign pos_x = XW'(pos_reg);
    assign cnt_x = XW'(count_reg);

    always_comb
    begin
        status_calc = pol_pkg::ST_OK;
        found_calc  = '0;
        do_ins      = 1'b0;
        do_rm_pos   = 1'b0;
        do_rm_match = 1'b0;
        count_next  = count_reg;
        case (act_reg)
            pol_pkg::ACT_INSERT:
            begin
                if (pos_x > cnt_x)
                begin
                    status_calc = pol_pkg::ST_BAD_POS;
                end
                else if (count_reg == CW'(CAPACITY))
                begin
                    status_calc = pol_pkg::ST_FULL;
                end
                else
                begin
                    do_ins     = 1'b1;
                    count_next = count_reg + CW'(1);
                end
            end
            pol_pkg::ACT_REMOVE_AT:
            begin
                if (pos_x >= cnt_x)
                begin
                    status_calc = pol_pkg::ST_BAD_POS;
                end
                else
                begin
                    do_rm_pos  = 1'b1;
                    count_next = count_reg - CW'(1);
                end
            end
            pol_pkg::ACT_REMOVE_EQ:
            begin
                if (!any_hit)
                begin
                    status_calc = pol_pkg::ST_NOT_FOUND;
                end
                else
                begin
                    do_rm_match = 1'b1;
                    count_next  = count_reg - CW'(1);
                end
            end
            pol_pkg::ACT_SEARCH:
            begin
                if (!any_hit)
                begin
                    status_calc = pol_pkg::ST_NOT_FOUND;
                end
                else
                begin
                    found_calc = pol_pkg::FOUND_W'(hit_index);
                end
            end
            default:
            begin
                status_calc = pol_pkg::ST_OK;
            end
        endcase
    end

    // Cells only move on the commit edge.
    assign cmd.ins      = commit && do_ins;
    assign cmd.rm_pos   = commit && do_rm_pos;
    assign cmd.rm_match = commit && do_rm_match;
    assign cmd.pos      = pos_reg;
    assign cmd.value    = val_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result register: loads on commit, drains when taken downstream.
    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (commit)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_valid_reg && !result_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            if (commit)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg <= action;
            val_reg <= value;
            pos_reg <= position;
        end
        if (commit)
        begin
            res_status_reg <= status_calc;
            res_found_reg  <= found_calc;
            res_count_reg  <= pol_pkg::COUNT_W'(count_next);
            res_empty_reg  <= (count_next == '0);
        end
    end

    assign result_valid   = res_valid_reg;
    assign status         = res_status_reg;
    assign found_position = res_found_reg;
    assign item_count     = res_count_reg;
    assign is_empty       = res_empty_reg;

endmodule

// File: hdl/pol_checker.sv
// Port-level checks for the positional ordered list, bound to the top level.
`timescale 1ns / 1ps

module pol_checker #(
    parameter int CAPACITY = 32
) (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                item_valid,
    input logic                                item_stall,
    input logic                                result_valid,
    input logic                                result_stall,
    input logic [pol_pkg::STATUS_W-1:0]        status,
    input logic [pol_pkg::FOUND_W-1:0]         found_position,
    input logic [pol_pkg::COUNT_W-1:0]         item_count,
    input logic                                is_empty
);

    // One transaction at a time: the cycle after acceptance is stalled.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall) |=> item_stall)
        else $error("transaction accepted back to back");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> (result_valid && $stable(status)
            && $stable(found_position) && $stable(item_count)))
        else $error("stalled result changed");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (is_empty == (item_count == '0)))
        else $error("empty flag disagrees with count");

    a_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (status != pol_pkg::ST_OK)) |-> (found_position == '0))
        else $error("found position set on failure");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (status == pol_pkg::ST_FULL))
            |-> (item_count == pol_pkg::COUNT_W'(CAPACITY)))
        else $error("full status below capacity");

endmodule

bind positional_ordered_list_core pol_checker #(
    .CAPACITY (CAPACITY)
) u_pol_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .status         (status),
    .found_position (found_position),
    .item_count     (item_count),
    .is_empty       (is_empty)
);

// File: sim/tb.sv
// Self-checking testbench for the positional ordered list core.
`timescale 1ns / 1ps

module tb;

    localparam int CAPACITY       = 32;
    localparam int IDLE_PCT       = 23;    // chance per cycle that a side idles
    localparam int HOLD_CYCLES    = 80;    // long receiver hold-off
    localparam int WATCHDOG_LIMIT = 1000;  // cycles with no transaction at all
    localparam int DRAIN_CYCLES   = 8;     // settle time after the last result

    // One predicted result transaction.
    typedef struct packed {
        logic [pol_pkg::STATUS_W-1:0] status;
        logic [pol_pkg::FOUND_W-1:0]  found;
        logic [pol_pkg::COUNT_W-1:0]  count;
        logic                         empty;
    } outcome_t;

    logic                                clk        = 1'b0;
    logic                                rst_n      = 1'b0;
    logic                                item_valid = 1'b0;
    logic                                item_stall;
    logic [pol_pkg::ACTION_W-1:0]        action     = pol_pkg::ACT_SEARCH;
    logic signed [pol_pkg::VALUE_W-1:0]  value      = '0;
    logic [pol_pkg::POS_W-1:0]           position   = '0;
    logic                                result_valid;
    logic                                result_stall = 1'b0;
    logic [pol_pkg::STATUS_W-1:0]        status;
    logic [pol_pkg::FOUND_W-1:0]         found_position;
    logic [pol_pkg::COUNT_W-1:0]         item_count;
    logic                                is_empty;

    // Shadow copy of the list contents, front of the queue is position 0.
    logic signed [pol_pkg::VALUE_W-1:0]  shadow_list[$];
    // Results predicted at input acceptance, oldest first.
    outcome_t                            pending_results[$];
    int                                  mismatch_count = 0;
    bit                                  steady  = 1'b0;  // suppresses random idling on both sides
    bit                                  hold_go = 1'b0;  // asks the receiver for one long hold-off

    positional_ordered_list_core #(
        .CAPACITY(CAPACITY)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .action        (action),
        .value         (value),
        .position      (position),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .status        (status),
        .found_position(found_position),
        .item_count    (item_count),
        .is_empty      (is_empty)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Apply one action to the shadow list and return the result it must produce.
    // Insert checks the position before the full condition, so a position past the
    // end of a full list reports a bad position.
    function automatic outcome_t predict_outcome(
        input logic [pol_pkg::ACTION_W-1:0] act,
        input logic signed [pol_pkg::VALUE_W-1:0] val,
        input logic [pol_pkg::POS_W-1:0] pos);
        outcome_t o;
        int       hit;
        o.status = pol_pkg::ST_OK;
        o.found  = '0;
        hit = -1;
        for (int i = 0; i < shadow_list.size(); i++)
            if (hit < 0 && shadow_list[i] == val)
                hit = i;
        case (act)
            pol_pkg::ACT_INSERT:
                if (int'(pos) > shadow_list.size())
                    o.status = pol_pkg::ST_BAD_POS;
                else if (shadow_list.size() >= CAPACITY)
                    o.status = pol_pkg::ST_FULL;
                else
                    shadow_list.insert(int'(pos), val);
            pol_pkg::ACT_REMOVE_AT:
                if (int'(pos) >= shadow_list.size())
                    o.status = pol_pkg::ST_BAD_POS;
                else
                    shadow_list.delete(int'(pos));
            pol_pkg::ACT_REMOVE_EQ:
                if (hit < 0)
                    o.status = pol_pkg::ST_NOT_FOUND;
                else
                    shadow_list.delete(hit);
            default:
                if (hit < 0)
                    o.status = pol_pkg::ST_NOT_FOUND;
                else
                    o.found = pol_pkg::FOUND_W'(hit);
        endcase
        o.count = pol_pkg::COUNT_W'(shadow_list.size());
        o.empty = (shadow_list.size() == 0);
        return o;
    endfunction

    // Offer one input transaction and wait for it to be taken. Valid stays high on
    // return; the next call either replaces the payload or idles.
    task automatic send_action(input logic [pol_pkg::ACTION_W-1:0] act,
                               input logic signed [pol_pkg::VALUE_W-1:0] val,
                               input logic [pol_pkg::POS_W-1:0] pos);
        if (!steady)
            while ($urandom_range(99) < IDLE_PCT)
            begin
                item_valid <= 1'b0;
                @(posedge clk);
            end
        item_valid <= 1'b1;
        action     <= act;
        value      <= val;
        position   <= pos;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        pending_results.push_back(predict_outcome(act, val, pos));
    endtask

    // Nearly half the values are drawn from the list itself so that matches and duplicates
    // are common, plus the signed extremes, zero, minus one and fully random words.
    function automatic logic signed [pol_pkg::VALUE_W-1:0] pick_value();
        int r;
        r = $urandom_range(99);
        if (r < 45 && shadow_list.size() > 0)
            return shadow_list[$urandom_range(shadow_list.size() - 1)];
        if (r < 65)
            case ($urandom_range(3))
                0:       return 32'sh8000_0000;
                1:       return 32'sh7fff_ffff;
                2:       return 32'sd0;
                default: return -32'sd1;
            endcase
        return signed'($urandom);
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] want_v,
                                          input logic [31:0] got_v);
        if (got_v !== want_v)
        begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want_v, got_v);
            mismatch_count++;
        end
    endfunction

    // Result side: check each accepted result against the oldest prediction, then
    // pick the stall for the next cycle (random, steady, or a long hold-off).
    initial
    begin : result_checker
        outcome_t want;
        int       hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && !result_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: unexpected result: expected none, actual status %0d count %0d",
                             $time, status, item_count);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    compare_field("status", 32'(want.status), 32'(status));
                    compare_field("found_position", 32'(want.found), 32'(found_position));
                    compare_field("item_count", 32'(want.count), 32'(item_count));
                    compare_field("is_empty", 32'(want.empty), 32'(is_empty));
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else if (hold_go)
            begin
                hold_go   = 1'b0;
                hold_left = HOLD_CYCLES;
                result_stall <= 1'b1;
            end
            else
                result_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
        end
    end

    // Ends the run if neither channel moves for too long.
    initial
    begin : watchdog
        int stale;
        stale = 0;
        while (stale < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
                stale = 0;
            else
                stale++;
        end
        $display("%0t: timeout, no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Empty list: every removal and search fails, insert past the end is rejected, insert at 0 succeeds.
    task automatic test_empty_list();
        send_action(pol_pkg::ACT_REMOVE_AT, 32'sd0, 6'd0);
        send_action(pol_pkg::ACT_REMOVE_EQ, 32'sd5, 6'd0);
        send_action(pol_pkg::ACT_SEARCH, 32'sd5, 6'd0);
        send_action(pol_pkg::ACT_INSERT, 32'sd1, 6'd1);
        send_action(pol_pkg::ACT_INSERT, 32'sh8000_0000, 6'd0);
    endtask

    // Front, middle and end inserts, first-match rules with duplicates, and
    // positions at and beyond the count.
    task automatic test_positions_and_matches();
        send_action(pol_pkg::ACT_INSERT, 32'sh7fff_ffff, 6'd1);   // append
        send_action(pol_pkg::ACT_INSERT, -32'sd1, 6'd1);          // middle
        send_action(pol_pkg::ACT_INSERT, 32'sd0, 6'd63);          // far past the end
        send_action(pol_pkg::ACT_SEARCH, 32'sh7fff_ffff, 6'd0);
        send_action(pol_pkg::ACT_SEARCH, 32'sh8000_0000, 6'd0);
        send_action(pol_pkg::ACT_INSERT, -32'sd1, 6'd0);          // duplicate at the front
        send_action(pol_pkg::ACT_SEARCH, -32'sd1, 6'd0);          // first of two matches
        send_action(pol_pkg::ACT_REMOVE_EQ, -32'sd1, 6'd0);
        send_action(pol_pkg::ACT_SEARCH, -32'sd1, 6'd0);
        send_action(pol_pkg::ACT_REMOVE_AT, 32'sd0, 6'd3);        // position equal to count
        send_action(pol_pkg::ACT_REMOVE_AT, 32'sd0, 6'd63);
        send_action(pol_pkg::ACT_REMOVE_AT, 32'sd0, 6'd2);        // last entry
        send_action(pol_pkg::ACT_REMOVE_AT, 32'sd0, 6'd0);        // first entry
        send_action(pol_pkg::ACT_REMOVE_EQ, 32'sd12345, 6'd0);
        send_action(pol_pkg::ACT_REMOVE_EQ, -32'sd1, 6'd0);       // list empty again
    endtask

    // Fill to capacity without idling, probe the full list, then drain it.
    task automatic test_fill_to_capacity();
        steady = 1'b1;
        while (shadow_list.size() < CAPACITY)
            send_action(pol_pkg::ACT_INSERT, pick_value(),
                        pol_pkg::POS_W'($urandom_range(shadow_list.size())));
        send_action(pol_pkg::ACT_INSERT, 32'sd77, pol_pkg::POS_W'(CAPACITY));      // full
        send_action(pol_pkg::ACT_INSERT, 32'sd77, pol_pkg::POS_W'(CAPACITY + 1));  // bad position wins
        send_action(pol_pkg::ACT_SEARCH, shadow_list[CAPACITY - 1], '0);
        steady = 1'b0;
        while (shadow_list.size() > 0)
            send_action(pol_pkg::ACT_REMOVE_AT, pick_value(),
                        pol_pkg::POS_W'($urandom_range(shadow_list.size() - 1)));
    endtask

    // Random actions; most positions are legal for the current count, some are
    // anywhere in the 6-bit range.
    task automatic test_random_mix(input int n_items, input int insert_pct);
        int                           r;
        int                           size;
        logic [pol_pkg::ACTION_W-1:0] act;
        logic [pol_pkg::POS_W-1:0]    pos;
        repeat (n_items)
        begin
            r    = $urandom_range(99);
            size = shadow_list.size();
            if (r < insert_pct)
                act = pol_pkg::ACT_INSERT;
            else if (r < insert_pct + (100 - insert_pct) / 3)
                act = pol_pkg::ACT_REMOVE_AT;
            else if (r < insert_pct + 2 * (100 - insert_pct) / 3)
                act = pol_pkg::ACT_REMOVE_EQ;
            else
                act = pol_pkg::ACT_SEARCH;
            if ($urandom_range(99) < 15)
                pos = pol_pkg::POS_W'($urandom_range(63));
            else if (act == pol_pkg::ACT_INSERT)
                pos = pol_pkg::POS_W'($urandom_range(size));
            else
                pos = (size > 0) ? pol_pkg::POS_W'($urandom_range(size - 1)) : '0;
            send_action(act, pick_value(), pos);
        end
    endtask

    // Receiver holds off for a long stretch while items keep coming, so the core
    // backs up and stalls its input.
    task automatic test_backpressure();
        steady  = 1'b1;
        hold_go = 1'b1;
        test_random_mix(40, 50);
        steady  = 1'b0;
    endtask

    initial
    begin : main_sequence
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_list();
        test_positions_and_matches();
        test_fill_to_capacity();
        test_random_mix(250, 40);
        test_backpressure();
        test_random_mix(170, 30);

        item_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: positional_ordered_list_core.f
hdl/pol_pkg.sv
hdl/pol_cell.sv
hdl/pol_first.sv
hdl/positional_ordered_list_core.sv
hdl/pol_checker.sv
sim/tb.sv
